// ===== design/chacha20_stream_cipher_unit_macros.svh =====
// ----------------------------------------------------------------------------
// ChaCha20 stream cipher unit assertion macros
// Shared concurrent assertion forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef CHACHA20_STREAM_CIPHER_UNIT_MACROS_SVH
`define CHACHA20_STREAM_CIPHER_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define CC20_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cc20 assertion failed");

// next-cycle implication, disabled during reset
`define CC20_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cc20 assertion failed");

`endif

// ===== design/cc20_pkg.sv =====
// ----------------------------------------------------------------------------
// ChaCha20 package
// Types, constants and the half quarter-round function shared by the unit.
// ----------------------------------------------------------------------------
package cc20_pkg;

  localparam logic [31:0] SIGMA_0 = 32'h61707865;
  localparam logic [31:0] SIGMA_1 = 32'h3320646e;
  localparam logic [31:0] SIGMA_2 = 32'h79622d32;
  localparam logic [31:0] SIGMA_3 = 32'h6b206574;

  // 10 double rounds, two half quarter-rounds per round
  localparam int unsigned RoundSteps = 40;
  localparam int unsigned StepW      = 6;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = 2;
  localparam int unsigned QueueCntW  = 3;

  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] REG_KEY_A      = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_KEY_B      = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_KEY_C      = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_KEY_D      = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_NONCE_LOW  = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_NONCE_HIGH = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_START_CTR  = 3'd6;

  typedef logic [15:0][31:0] cc_block_t;
  typedef logic [3:0][31:0]  cc_quad_t;

  typedef struct packed {
    logic [63:0] key_a;
    logic [63:0] key_b;
    logic [63:0] key_c;
    logic [63:0] key_d;
    logic [63:0] nonce_low;
    logic [31:0] nonce_high;
    logic [31:0] start_counter;
  } cc_cfg_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       first;
    logic       new_block;
    logic [5:0] pos;
  } cc_item_t;

  typedef struct packed {
    logic      start;
    cc_block_t init;
  } cc_core_req_t;

  typedef struct packed {
    logic      done;
    cc_block_t ks;
  } cc_core_rsp_t;

  // one half of a quarter round: rotations 16/12 first, then 8/7
  function automatic cc_quad_t half_qr(input logic [31:0] a, input logic [31:0] b,
                                       input logic [31:0] c, input logic [31:0] d,
                                       input logic second);
    logic [31:0] a1;
    logic [31:0] dx;
    logic [31:0] d1;
    logic [31:0] c1;
    logic [31:0] bx;
    logic [31:0] b1;
    cc_quad_t    res;
    a1 = a + b;
    dx = d ^ a1;
    d1 = second ? {dx[23:0], dx[31:24]} : {dx[15:0], dx[31:16]};
    c1 = c + d1;
    bx = b ^ c1;
    b1 = second ? {bx[24:0], bx[31:25]} : {bx[19:0], bx[31:20]};
    res[0] = a1;
    res[1] = b1;
    res[2] = c1;
    res[3] = d1;
    return res;
  endfunction

endpackage

// ===== design/cc20_front.sv =====
// ----------------------------------------------------------------------------
// ChaCha20 front end
// Accepts message bytes, tags block and message starts, queues them.
// ----------------------------------------------------------------------------
module cc20_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_valid_i,
  output logic               s_ready_o,
  input  logic [7:0]         s_data_i,
  input  logic               s_last_i,
  input  logic               pop_i,
  output logic               head_valid_o,
  output cc20_pkg::cc_item_t head_o
);

  cc20_pkg::cc_item_t mem_q [cc20_pkg::QueueDepth];

  logic [cc20_pkg::QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [cc20_pkg::QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [cc20_pkg::QueueCntW-1:0] count_q, count_d;
  logic                           active_q, active_d;
  logic [5:0]                     pos_q, pos_d;
  logic                           push;
  logic                           pop;
  cc20_pkg::cc_item_t             item;

  function automatic logic [cc20_pkg::QueueCntW-1:0] QueueCntAdj(input logic b);
    return {{(cc20_pkg::QueueCntW-1){1'b0}}, b};
  endfunction

  assign s_ready_o    = (count_q != cc20_pkg::QueueCntW'(cc20_pkg::QueueDepth));
  assign push         = s_valid_i && s_ready_o;
  assign head_valid_o = (count_q != '0);
  assign pop          = pop_i && head_valid_o;
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    item.data      = s_data_i;
    item.last      = s_last_i;
    item.first     = !active_q;
    item.new_block = !active_q || (pos_q == '0);
    item.pos       = active_q ? pos_q : 6'd0;

    wr_ptr_d = push ? wr_ptr_q + cc20_pkg::QueuePtrW'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + cc20_pkg::QueuePtrW'(1) : rd_ptr_q;
    count_d  = count_q + QueueCntAdj(push) - QueueCntAdj(pop);

    active_d = active_q;
    pos_d    = pos_q;
    if (push) begin
      active_d = !s_last_i;
      pos_d    = s_last_i ? 6'd0 : item.pos + 6'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
      active_q <= 1'b0;
      pos_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
      active_q <= active_d;
      pos_q    <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item;
    end
  end

endmodule

// ===== design/cc20_core.sv =====
// ----------------------------------------------------------------------------
// ChaCha20 block core
// Iterative block function: four half quarter-rounds per cycle, then add-back.
// ----------------------------------------------------------------------------
module cc20_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cc20_pkg::cc_core_req_t req_i,
  output cc20_pkg::cc_core_rsp_t rsp_o
);

  typedef enum logic [1:0] {
    C_IDLE,
    C_ROUND,
    C_ADD
  } state_e;

  state_e                         state_q;
  logic [cc20_pkg::StepW-1:0]     step_q;
  logic                           done_q;
  cc20_pkg::cc_block_t            ks_q;
  cc20_pkg::cc_block_t            x_q;
  cc20_pkg::cc_block_t            x_d;
  cc20_pkg::cc_block_t            init_q;
  cc20_pkg::cc_block_t            x_step;
  cc20_pkg::cc_block_t            sum;
  logic                           diag;
  logic                           half;

  assign diag = step_q[1];
  assign half = step_q[0];

  always_comb begin
    logic [1:0]         lb;
    logic [1:0]         lc;
    logic [1:0]         ld;
    cc20_pkg::cc_quad_t quad;
    x_step = x_q;
    for (int l = 0; l < 4; l++) begin
      lb   = 2'(l) + {1'b0, diag};
      lc   = 2'(l) + {diag, 1'b0};
      ld   = 2'(l) + {diag, diag};
      quad = cc20_pkg::half_qr(x_q[{2'b00, 2'(l)}], x_q[{2'b01, lb}],
                               x_q[{2'b10, lc}], x_q[{2'b11, ld}], half);
      x_step[{2'b00, 2'(l)}] = quad[0];
      x_step[{2'b01, lb}]    = quad[1];
      x_step[{2'b10, lc}]    = quad[2];
      x_step[{2'b11, ld}]    = quad[3];
    end
  end

  always_comb begin
    for (int w = 0; w < 16; w++) begin
      sum[w] = x_q[w] + init_q[w];
    end
  end

  always_comb begin
    x_d = x_q;
    if (state_q == C_IDLE && req_i.start) begin
      x_d = req_i.init;
    end else if (state_q == C_ROUND) begin
      x_d = x_step;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    if (state_q == C_IDLE && req_i.start) begin
      init_q <= req_i.init;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      step_q  <= '0;
      done_q  <= 1'b0;
      ks_q    <= '0;
    end else begin
      done_q <= (state_q == C_ADD);
      case (state_q)
        C_IDLE: begin
          if (req_i.start) begin
            step_q  <= '0;
            state_q <= C_ROUND;
          end
        end
        C_ROUND: begin
          step_q <= step_q + cc20_pkg::StepW'(1);
          if (step_q == cc20_pkg::StepW'(cc20_pkg::RoundSteps - 1)) begin
            state_q <= C_ADD;
          end
        end
        C_ADD: begin
          ks_q    <= sum;
          state_q <= C_IDLE;
        end
        default: begin
          state_q <= C_IDLE;
        end
      endcase
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.ks   = ks_q;

endmodule

// ===== design/cc20_back.sv =====
// ----------------------------------------------------------------------------
// ChaCha20 back end
// Pops queued bytes, requests keystream blocks, XORs and holds the result.
// ----------------------------------------------------------------------------
module cc20_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cc20_pkg::cc_cfg_t      cfg_i,
  input  logic                   head_valid_i,
  input  cc20_pkg::cc_item_t     head_i,
  output logic                   pop_o,
  output cc20_pkg::cc_core_req_t core_req_o,
  input  cc20_pkg::cc_core_rsp_t core_rsp_i,
  output logic                   m_valid_o,
  input  logic                   m_ready_i,
  output logic [7:0]             m_data_o,
  output logic                   m_last_o
);

  typedef enum logic [1:0] {
    B_FETCH,
    B_GEN,
    B_EMIT
  } state_e;

  state_e      state_q, state_d;
  logic [31:0] ctr_q, ctr_d;
  logic        m_valid_q;
  logic [7:0]  m_data_q;
  logic        m_last_q;
  logic        out_free;
  logic        load;
  logic        start;
  logic [511:0] ks_flat;
  logic [7:0]  ks_byte;

  assign out_free = !m_valid_q || m_ready_i;
  assign ks_flat  = core_rsp_i.ks;
  assign ks_byte  = ks_flat[{head_i.pos, 3'b000} +: 8];

  always_comb begin
    state_d = state_q;
    ctr_d   = ctr_q;
    start   = 1'b0;
    load    = 1'b0;
    case (state_q)
      B_FETCH: begin
        if (head_valid_i) begin
          if (head_i.new_block) begin
            ctr_d   = head_i.first ? cfg_i.start_counter : ctr_q + 32'd1;
            start   = 1'b1;
            state_d = B_GEN;
          end else if (out_free) begin
            load = 1'b1;
          end
        end
      end
      B_GEN: begin
        if (core_rsp_i.done) begin
          state_d = B_EMIT;
        end
      end
      B_EMIT: begin
        if (out_free) begin
          load    = 1'b1;
          state_d = B_FETCH;
        end
      end
      default: begin
        state_d = B_FETCH;
      end
    endcase
  end

  assign pop_o = load;

  always_comb begin
    core_req_o.start    = start;
    core_req_o.init[0]  = cc20_pkg::SIGMA_0;
    core_req_o.init[1]  = cc20_pkg::SIGMA_1;
    core_req_o.init[2]  = cc20_pkg::SIGMA_2;
    core_req_o.init[3]  = cc20_pkg::SIGMA_3;
    core_req_o.init[4]  = cfg_i.key_a[31:0];
    core_req_o.init[5]  = cfg_i.key_a[63:32];
    core_req_o.init[6]  = cfg_i.key_b[31:0];
    core_req_o.init[7]  = cfg_i.key_b[63:32];
    core_req_o.init[8]  = cfg_i.key_c[31:0];
    core_req_o.init[9]  = cfg_i.key_c[63:32];
    core_req_o.init[10] = cfg_i.key_d[31:0];
    core_req_o.init[11] = cfg_i.key_d[63:32];
    core_req_o.init[12] = ctr_d;
    core_req_o.init[13] = cfg_i.nonce_low[31:0];
    core_req_o.init[14] = cfg_i.nonce_low[63:32];
    core_req_o.init[15] = cfg_i.nonce_high;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= B_FETCH;
      ctr_q     <= '0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
      m_last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ctr_q   <= ctr_d;
      if (load) begin
        m_valid_q <= 1'b1;
        m_data_q  <= head_i.data ^ ks_byte;
        m_last_q  <= head_i.last;
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  assign m_valid_o = m_valid_q;
  assign m_data_o  = m_data_q;
  assign m_last_o  = m_last_q;

endmodule

// ===== design/chacha20_stream_cipher_unit.sv =====
// ----------------------------------------------------------------------------
// ChaCha20 stream cipher unit
// XORs a byte stream with the ChaCha20 keystream (20 rounds, 96-bit nonce).
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one message byte per transfer, tlast on the final byte.
//   m_axis returns the XORed byte with the same tlast, in order.
//   cfg writes key, nonce and start counter by index; write only while idle.
// Keystream blocks:
//   A byte that opens a 64-byte block waits for the block core, which runs
//   four half quarter-rounds per cycle through its round steps and then an
//   add-back step per block. Other bytes of the block leave one per cycle
//   while the queue holds them and m_axis is ready.
//   A four-entry input queue takes up to four bytes while a block is made.
// Reset:
//   Clears queue, counter and output; key and nonce read zero, the start
//   counter reads one. The first byte after reset opens a new message.
// Stall:
//   A stalled m_axis holds its byte; the queue fills and s_axis_tready drops.
// ----------------------------------------------------------------------------
module chacha20_stream_cipher_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,  // [7:0] data_byte
  input  logic                         s_axis_tlast,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [7:0]                   m_axis_tdata,  // [7:0] cipher_byte
  output logic                         m_axis_tlast,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [cc20_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [63:0]                  cfg_data_i
);

  cc20_pkg::cc_cfg_t      cfg_q;
  cc20_pkg::cc_item_t     head;
  cc20_pkg::cc_core_req_t core_req;
  cc20_pkg::cc_core_rsp_t core_rsp;
  logic                   head_valid;
  logic                   pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.key_a         <= '0;
      cfg_q.key_b         <= '0;
      cfg_q.key_c         <= '0;
      cfg_q.key_d         <= '0;
      cfg_q.nonce_low     <= '0;
      cfg_q.nonce_high    <= '0;
      cfg_q.start_counter <= 32'd1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        cc20_pkg::REG_KEY_A:      cfg_q.key_a         <= cfg_data_i;
        cc20_pkg::REG_KEY_B:      cfg_q.key_b         <= cfg_data_i;
        cc20_pkg::REG_KEY_C:      cfg_q.key_c         <= cfg_data_i;
        cc20_pkg::REG_KEY_D:      cfg_q.key_d         <= cfg_data_i;
        cc20_pkg::REG_NONCE_LOW:  cfg_q.nonce_low     <= cfg_data_i;
        cc20_pkg::REG_NONCE_HIGH: cfg_q.nonce_high    <= cfg_data_i[31:0];
        cc20_pkg::REG_START_CTR:  cfg_q.start_counter <= cfg_data_i[31:0];
        default: begin
        end
      endcase
    end
  end

  cc20_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .s_data_i    (s_axis_tdata),
    .s_last_i    (s_axis_tlast),
    .pop_i       (pop),
    .head_valid_o(head_valid),
    .head_o      (head)
  );

  cc20_core u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (core_req),
    .rsp_o (core_rsp)
  );

  cc20_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .head_valid_i(head_valid),
    .head_i      (head),
    .pop_o       (pop),
    .core_req_o  (core_req),
    .core_rsp_i  (core_rsp),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_data_o    (m_axis_tdata),
    .m_last_o    (m_axis_tlast)
  );

endmodule

// ===== design/cc20_checker.sv =====
// ----------------------------------------------------------------------------
// ChaCha20 port checker
// Tracks bytes in flight at the ports and checks output hold and bounds.
// ----------------------------------------------------------------------------
`include "chacha20_stream_cipher_unit_macros.svh"

module cc20_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast
);

  logic [3:0] inflight_q, inflight_d;
  logic       s_fire;
  logic       m_fire;

  assign s_fire     = s_axis_tvalid && s_axis_tready;
  assign m_fire     = m_axis_tvalid && m_axis_tready;
  assign inflight_d = inflight_q + {3'b000, s_fire} - {3'b000, m_fire};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_d;
    end
  end

  `CC20_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
                    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
  `CC20_ASSERT_NOW(a_no_invent, clk_i, rst_ni, m_axis_tvalid, inflight_q != 4'd0)
  `CC20_ASSERT_NOW(a_bounded, clk_i, rst_ni, 1'b1, inflight_q <= 4'd5)
  `CC20_ASSERT_NOW(a_ready_full, clk_i, rst_ni, !s_axis_tready, inflight_q >= 4'd4)

endmodule

bind chacha20_stream_cipher_unit cc20_checker u_cc20_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tlast (m_axis_tlast)
);

// ===== tb/sv/tb_chacha20_stream_cipher_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ChaCha20 stream cipher unit testbench
// Streams message bytes through the unit under changing key, nonce and start
// counter settings and checks every output byte and tlast against typed values or
// a local ChaCha20 keystream calculation. A short directed table covers the known
// zero-key blocks, single-byte messages, a key change inside an open message
// and counter extremes. Random messages follow, some of them long enough to
// cross block boundaries and wrap the counter. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_chacha20_stream_cipher_unit;

  localparam int unsigned RandomBytes = 1750;
  localparam int unsigned PlanBytes   = RandomBytes + 23;
  localparam int unsigned CycleLimit  = 1000000;
  localparam int unsigned DrainCycles = 200;

  typedef logic [31:0] word_t;

  typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e                    kind;
    logic [cc20_pkg::CfgIdxW-1:0] idx;
    logic [63:0]                  val;
    logic [7:0]                   data;
    logic                         last;
    bit                           known;
    logic [7:0]                   cipher;
  } dir_row_t;

  typedef struct {
    logic [7:0] cipher;
    logic       last;
  } cipher_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [7:0]                   s_axis_tdata = 8'h00;
  logic                         s_axis_tlast = 1'b0;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [7:0]                   m_axis_tdata;
  logic                         m_axis_tlast;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [cc20_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [63:0]                  cfg_data = '0;

  // local copy of the configuration and cipher state
  logic [63:0] key_cfg [4];
  logic [63:0] nonce_lo;
  word_t       nonce_hi;
  word_t       ctr_start;
  word_t       blk_ctr;
  logic [5:0]  byte_pos;
  bit          msg_open;
  word_t       ks_w [16];
  word_t       mix_w [16];

  cipher_t     pending_cipher_q [$];
  cipher_t     got_want;
  dir_row_t    dir_rows [$];
  int unsigned mismatch_cnt = 0;
  int unsigned bytes_sent = 0;
  int unsigned tx_idle_pct = 18;
  int unsigned rx_idle_pct = 61;
  int unsigned cycle_cnt = 0;

  chacha20_stream_cipher_unit dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // values at the falling edge are the ones the next rising edge transfers
  always @(negedge clk) begin
    if (rst_n && m_axis_tvalid && m_axis_tready) begin
      if (pending_cipher_q.size() == 0) begin
        $display("%0t unexpected output: actual %02h last %0b", $time, m_axis_tdata,
                 m_axis_tlast);
        mismatch_cnt++;
      end else begin
        got_want = pending_cipher_q.pop_front();
        if (m_axis_tdata !== got_want.cipher) begin
          $display("%0t cipher byte mismatch: expected %02h actual %02h", $time,
                   got_want.cipher, m_axis_tdata);
          mismatch_cnt++;
        end
        if (m_axis_tlast !== got_want.last) begin
          $display("%0t tlast mismatch: expected %0b actual %0b", $time, got_want.last,
                   m_axis_tlast);
          mismatch_cnt++;
        end
      end
    end
  end

  function automatic word_t rotl(word_t v, int r);
    return (v << r) | (v >> (32 - r));
  endfunction

  function automatic void mix_quad(int a, int b, int c, int d);
    mix_w[a] = mix_w[a] + mix_w[b]; mix_w[d] = rotl(mix_w[d] ^ mix_w[a], 16);
    mix_w[c] = mix_w[c] + mix_w[d]; mix_w[b] = rotl(mix_w[b] ^ mix_w[c], 12);
    mix_w[a] = mix_w[a] + mix_w[b]; mix_w[d] = rotl(mix_w[d] ^ mix_w[a], 8);
    mix_w[c] = mix_w[c] + mix_w[d]; mix_w[b] = rotl(mix_w[b] ^ mix_w[c], 7);
  endfunction

  function automatic void refresh_keystream();
    word_t init_w [16];
    init_w[0] = cc20_pkg::SIGMA_0;
    init_w[1] = cc20_pkg::SIGMA_1;
    init_w[2] = cc20_pkg::SIGMA_2;
    init_w[3] = cc20_pkg::SIGMA_3;
    for (int k = 0; k < 4; k++) begin
      init_w[4 + 2 * k] = key_cfg[k][31:0];
      init_w[5 + 2 * k] = key_cfg[k][63:32];
    end
    init_w[12] = blk_ctr;
    init_w[13] = nonce_lo[31:0];
    init_w[14] = nonce_lo[63:32];
    init_w[15] = nonce_hi;
    for (int i = 0; i < 16; i++) mix_w[i] = init_w[i];
    for (int r = 0; r < 10; r++) begin
      mix_quad(0, 4, 8, 12);
      mix_quad(1, 5, 9, 13);
      mix_quad(2, 6, 10, 14);
      mix_quad(3, 7, 11, 15);
      mix_quad(0, 5, 10, 15);
      mix_quad(1, 6, 11, 12);
      mix_quad(2, 7, 8, 13);
      mix_quad(3, 4, 9, 14);
    end
    for (int i = 0; i < 16; i++) ks_w[i] = mix_w[i] + init_w[i];
  endfunction

  function automatic logic [7:0] encrypt_byte(logic [7:0] d, logic l);
    word_t ks;
    if (!msg_open) begin
      blk_ctr  = ctr_start;
      byte_pos = '0;
      refresh_keystream();
      msg_open = 1'b1;
    end else if (byte_pos == 6'd0) begin
      blk_ctr = blk_ctr + 32'd1;
      refresh_keystream();
    end
    ks = ks_w[byte_pos[5:2]] >> {byte_pos[1:0], 3'b000};
    byte_pos = byte_pos + 6'd1;
    if (l) begin
      msg_open = 1'b0;
      byte_pos = '0;
    end
    return d ^ ks[7:0];
  endfunction

  function automatic void apply_reg(logic [cc20_pkg::CfgIdxW-1:0] idx, logic [63:0] val);
    case (idx)
      cc20_pkg::REG_KEY_A:      key_cfg[0] = val;
      cc20_pkg::REG_KEY_B:      key_cfg[1] = val;
      cc20_pkg::REG_KEY_C:      key_cfg[2] = val;
      cc20_pkg::REG_KEY_D:      key_cfg[3] = val;
      cc20_pkg::REG_NONCE_LOW:  nonce_lo = val;
      cc20_pkg::REG_NONCE_HIGH: nonce_hi = val[31:0];
      cc20_pkg::REG_START_CTR:  ctr_start = val[31:0];
      default: ;
    endcase
  endfunction

  function automatic void add_byte(logic [7:0] d, logic l, bit known, logic [7:0] c);
    dir_row_t row;
    row.kind   = ROW_BYTE;
    row.idx    = '0;
    row.val    = '0;
    row.data   = d;
    row.last   = l;
    row.known  = known;
    row.cipher = c;
    dir_rows.push_back(row);
  endfunction

  function automatic void add_cfg(logic [cc20_pkg::CfgIdxW-1:0] idx, logic [63:0] val);
    dir_row_t row;
    row.kind   = ROW_CFG;
    row.idx    = idx;
    row.val    = val;
    row.data   = '0;
    row.last   = 1'b0;
    row.known  = 1'b0;
    row.cipher = '0;
    dir_rows.push_back(row);
  endfunction

  task automatic send_byte(input logic [7:0] d, input logic l, input bit known,
                           input logic [7:0] typed);
    bit      hit;
    cipher_t want;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'($urandom);
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tlast  <= l;
    do begin
      @(negedge clk);
      hit = s_axis_tready;
      @(posedge clk);
    end while (!hit);
    want.cipher = encrypt_byte(d, l);
    if (known) want.cipher = typed;
    want.last = l;
    pending_cipher_q.push_back(want);
    bytes_sent++;
    if (bytes_sent == PlanBytes / 3) begin
      tx_idle_pct = 61;
      rx_idle_pct = 18;
    end else if (bytes_sent == 2 * PlanBytes / 3) begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
  endtask

  // hold the input side until every queued byte has come out
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    wait (pending_cipher_q.size() == 0);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [cc20_pkg::CfgIdxW-1:0] idx,
                           input logic [63:0] val, input bit hold);
    bit hit;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do begin
      @(negedge clk);
      hit = cfg_ready;
      @(posedge clk);
    end while (!hit);
    apply_reg(idx, val);
    if (!hold) cfg_valid <= 1'b0;
  endtask

  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 45) return $urandom_range(8, 1);
    if (r < 70) return $urandom_range(63, 9);
    if (r < 90) return $urandom_range(66, 62);
    return $urandom_range(140, 100);
  endfunction

  function automatic logic [7:0] pick_data();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) return 8'h00;
    if (r < 16) return 8'hff;
    return 8'($urandom);
  endfunction

  task automatic random_phase();
    int unsigned                  mode;
    int unsigned                  n_msg;
    int unsigned                  len;
    int unsigned                  n_wr;
    int unsigned                  forced;
    bit                           sel [7];
    logic [63:0]                  vals [7];
    logic [cc20_pkg::CfgIdxW-1:0] reg_idx [7];
    bit                           keep_open;
    mode = $urandom_range(5);
    reg_idx[0] = cc20_pkg::REG_KEY_A;
    reg_idx[1] = cc20_pkg::REG_KEY_B;
    reg_idx[2] = cc20_pkg::REG_KEY_C;
    reg_idx[3] = cc20_pkg::REG_KEY_D;
    reg_idx[4] = cc20_pkg::REG_NONCE_LOW;
    reg_idx[5] = cc20_pkg::REG_NONCE_HIGH;
    reg_idx[6] = cc20_pkg::REG_START_CTR;
    forced = $urandom_range(6);
    n_wr = 0;
    for (int i = 0; i < 7; i++) begin
      case (mode)
        0: vals[i] = '0;
        1: vals[i] = '1;
        default: vals[i] = {$urandom, $urandom};
      endcase
      sel[i] = (mode < 2) || (i == forced) || $urandom_range(1);
      if (sel[i]) n_wr++;
    end
    if (mode >= 2 && $urandom_range(3) == 0)
      vals[6] = {$urandom, 32'hffffffff - $urandom_range(1)};
    settle();
    for (int i = 0; i < 7; i++) begin
      if (sel[i]) begin
        n_wr--;
        write_reg(reg_idx[i], vals[i], n_wr != 0);
      end
    end
    n_msg = $urandom_range(4, 1);
    keep_open = ($urandom_range(3) == 0);
    for (int m = 0; m < n_msg; m++) begin
      len = (m == 0 && mode == 1) ? $urandom_range(80, 65) : pick_len();
      for (int b = 0; b < len; b++)
        send_byte(pick_data(), (b == len - 1) && !(keep_open && m == n_msg - 1), 1'b0,
                  8'h00);
    end
  endtask

  initial begin
    key_cfg[0] = '0;
    key_cfg[1] = '0;
    key_cfg[2] = '0;
    key_cfg[3] = '0;
    nonce_lo   = '0;
    nonce_hi   = '0;
    ctr_start  = 32'd1;
    blk_ctr    = '0;
    byte_pos   = '0;
    msg_open   = 1'b0;

    // zero key and nonce, start counter one after reset
    add_byte(8'h00, 1'b0, 1'b1, 8'h9f);
    add_byte(8'h00, 1'b0, 1'b1, 8'h07);
    add_byte(8'h00, 1'b0, 1'b1, 8'he7);
    add_byte(8'h00, 1'b0, 1'b1, 8'hbe);
    add_byte(8'hff, 1'b0, 1'b0, 8'h00);
    add_byte(8'h80, 1'b0, 1'b0, 8'h00);
    add_byte(8'h01, 1'b0, 1'b0, 8'h00);
    add_byte(8'h7f, 1'b1, 1'b0, 8'h00);
    add_byte(8'h5a, 1'b1, 1'b0, 8'h00);
    add_byte(8'ha5, 1'b1, 1'b0, 8'h00);
    add_cfg(cc20_pkg::REG_START_CTR, 64'h0);
    add_byte(8'h00, 1'b0, 1'b1, 8'h76);
    add_byte(8'h00, 1'b0, 1'b1, 8'hb8);
    add_byte(8'h00, 1'b0, 1'b1, 8'he0);
    add_byte(8'h00, 1'b0, 1'b1, 8'had);
    // key change inside an open message leaves the current block alone
    add_cfg(cc20_pkg::REG_KEY_A, '1);
    add_byte(8'h00, 1'b1, 1'b1, 8'ha0);
    add_cfg(cc20_pkg::REG_KEY_B, '1);
    add_cfg(cc20_pkg::REG_KEY_C, '1);
    add_cfg(cc20_pkg::REG_KEY_D, '1);
    add_cfg(cc20_pkg::REG_NONCE_LOW, '1);
    add_cfg(cc20_pkg::REG_NONCE_HIGH, '1);
    add_cfg(cc20_pkg::REG_START_CTR, '1);
    add_byte(8'hff, 1'b0, 1'b0, 8'h00);
    add_byte(8'h00, 1'b0, 1'b0, 8'h00);
    add_byte(8'h3c, 1'b0, 1'b0, 8'h00);
    add_byte(8'hc3, 1'b1, 1'b0, 8'h00);
    add_cfg(cc20_pkg::REG_KEY_A, 64'h0706050403020100);
    add_cfg(cc20_pkg::REG_KEY_B, 64'h0f0e0d0c0b0a0908);
    add_cfg(cc20_pkg::REG_KEY_C, 64'h1716151413121110);
    add_cfg(cc20_pkg::REG_KEY_D, 64'h1f1e1d1c1b1a1918);
    add_cfg(cc20_pkg::REG_NONCE_LOW, 64'h4a00000009000000);
    add_cfg(cc20_pkg::REG_NONCE_HIGH, 64'h0);
    add_cfg(cc20_pkg::REG_START_CTR, 64'h1);
    add_byte(8'h00, 1'b0, 1'b0, 8'h00);
    add_byte(8'h00, 1'b0, 1'b0, 8'h00);
    add_byte(8'hff, 1'b0, 1'b0, 8'h00);
    add_byte(8'h55, 1'b1, 1'b0, 8'h00);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < dir_rows.size(); i++) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        if (i == 0 || dir_rows[i - 1].kind != ROW_CFG) settle();
        write_reg(dir_rows[i].idx, dir_rows[i].val,
                  (i + 1 < dir_rows.size()) && (dir_rows[i + 1].kind == ROW_CFG));
      end else begin
        send_byte(dir_rows[i].data, dir_rows[i].last, dir_rows[i].known,
                  dir_rows[i].cipher);
      end
    end

    while (bytes_sent < PlanBytes) random_phase();

    s_axis_tvalid <= 1'b0;
    wait (pending_cipher_q.size() == 0);
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
